// ===== hdl/upd_pkg.sv =====
`default_nettype none

package upd_pkg;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CASE_GAP   = 8'h20;
  localparam logic [7:0] ALPHA_BIAS = 8'h37;

  // input kind codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // most results one input transaction can cause
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = 2;

  // default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } upd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_terminator;
    logic       last;
  } upd_out_t;

  // one result as queued, before the last flag is known
  typedef struct packed {
    logic [7:0] data;
    logic       term;
  } upd_res_t;

  // all results of one input transaction
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    upd_res_t [MAX_RESULTS-1:0]   res;
  } upd_cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_F));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] v;
    u = (c >= CH_LOWER_A) ? c - CASE_GAP : c;
    v = (u >= CH_UPPER_A) ? u - ALPHA_BIAS : u - CH_ZERO;
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/upd_front.sv =====
`default_nettype none

module upd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire upd_pkg::upd_in_t in_data,
  input  wire logic             queue_full,
  output logic                  push,
  output upd_pkg::upd_cmd_t     cmd
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;
  logic       in_fire;

  assign in_ready = ~queue_full;
  assign in_fire  = in_valid & in_ready;

  // classify the transaction and build its list of results
  always_comb begin
    upd_pkg::upd_res_t [upd_pkg::MAX_RESULTS-1:0] res;
    logic [upd_pkg::CNT_W-1:0] n;
    logic [7:0] c;
    logic       do_plain;
    res             = '0;
    n               = '0;
    c               = in_data.in_byte;
    do_plain        = 1'b0;
    phase_next      = phase;
    held_digit_next = held_digit;
    if (in_data.kind == upd_pkg::KIND_END) begin
      if (phase != PH_IDLE) begin
        res[n] = '{data: upd_pkg::CH_PERCENT, term: 1'b0};
        n      = n + 1'b1;
      end
      if (phase == PH_DIGIT) begin
        res[n] = '{data: held_digit, term: 1'b0};
        n      = n + 1'b1;
      end
      res[n]          = '{data: 8'h00, term: 1'b1};
      n               = n + 1'b1;
      phase_next      = PH_IDLE;
      held_digit_next = 8'h00;
    end else begin
      case (phase)
        PH_PCT: begin
          if (upd_pkg::is_hex(c)) begin
            held_digit_next = c;
            phase_next      = PH_DIGIT;
          end else begin
            res[n]     = '{data: upd_pkg::CH_PERCENT, term: 1'b0};
            n          = n + 1'b1;
            phase_next = PH_IDLE;
            do_plain   = 1'b1;
          end
        end
        PH_DIGIT: begin
          if (upd_pkg::is_hex(c)) begin
            res[n] = '{data: {upd_pkg::hex_nibble(held_digit), upd_pkg::hex_nibble(c)},
                       term: 1'b0};
            n      = n + 1'b1;
          end else begin
            res[n] = '{data: upd_pkg::CH_PERCENT, term: 1'b0};
            n      = n + 1'b1;
            res[n] = '{data: held_digit, term: 1'b0};
            n      = n + 1'b1;
            do_plain = 1'b1;
          end
          phase_next      = PH_IDLE;
          held_digit_next = 8'h00;
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase
      // ordinary byte handling with nothing held
      if (do_plain) begin
        if (c == upd_pkg::CH_PERCENT) begin
          phase_next = PH_PCT;
        end else if (c == upd_pkg::CH_PLUS) begin
          res[n] = '{data: upd_pkg::CH_SPACE, term: 1'b0};
          n      = n + 1'b1;
        end else begin
          res[n] = '{data: c, term: 1'b0};
          n      = n + 1'b1;
        end
      end
    end
    cmd.res   = res;
    cmd.count = n;
    push      = in_fire & (n != '0);
  end

  // escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'h00;
    end else if (in_fire) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

  // an end marker always leaves nothing held
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_data.kind == upd_pkg::KIND_END) |=> phase == PH_IDLE)
    else $error("escape state not cleared after end marker");

endmodule

`default_nettype wire

// ===== hdl/upd_queue.sv =====
`default_nettype none

module upd_queue #(
  parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire upd_pkg::upd_cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output upd_pkg::upd_cmd_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  upd_pkg::upd_cmd_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== hdl/upd_back.sv =====
`default_nettype none

module upd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire upd_pkg::upd_cmd_t cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output upd_pkg::upd_out_t      out_data
);

  logic [upd_pkg::CNT_W-1:0] idx;
  logic                      at_last;
  logic                      out_fire;

  assign at_last   = (idx == cmd.count - 1'b1);
  assign out_valid = cmd_valid;
  assign out_fire  = out_valid & out_ready;
  assign pop       = out_fire & at_last;

  // present the current result of the head command
  always_comb begin
    out_data.out_byte      = cmd.res[idx].data;
    out_data.is_terminator = cmd.res[idx].term;
    out_data.last          = at_last;
  end

  // step through the results of the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_fire) begin
      idx <= at_last ? '0 : idx + 1'b1;
    end
  end

  a_term_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_terminator |-> out_data.last)
    else $error("terminator is not the last result of its transaction");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (idx < cmd.count))
    else $error("result index beyond command length");

endmodule

`default_nettype wire

// ===== hdl/url_percent_decoder_top.sv =====
`default_nettype none

// Streaming URL percent-decoder with '+' as space. Each input transaction
// carries one encoded byte or an end-of-string marker and causes zero to
// three result transactions; the final one of each carries last. "%hh"
// (either case) gives one byte, '+' gives a space, a broken escape is passed
// on literally, and the end marker flushes what is held and then gives a
// terminator result with out_byte zero. The front classifies one input per
// cycle while the queue has room and writes its results as one command into
// a small queue; the back sends one result per cycle while out_ready is high.
// So an input that gives several results holds the output until all of them
// are sent; input stalls only once the queue (QUEUE_DEPTH commands) is full.
// No initialization pass is needed after reset.
module url_percent_decoder_top #(
  parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire upd_pkg::upd_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output upd_pkg::upd_out_t     out_data
);

  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_not_empty;
  upd_pkg::upd_cmd_t push_cmd;
  upd_pkg::upd_cmd_t head_cmd;

  // classify and build commands
  upd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // decouple front from back
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .head      (head_cmd)
  );

  // emit results one per transaction
  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_not_empty),
    .cmd       (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
